// ----- src/height_grid_bilinear_sampler_core_macros.svh -----
// Assertion macros shared by the height grid sampler RTL.
`ifndef HEIGHT_GRID_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define HEIGHT_GRID_BILINEAR_SAMPLER_CORE_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define HGBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define HGBS_ASSERT_NEVER(label, expr, msg) \
	`HGBS_ASSERT(label, !(expr), msg)

`endif

// ----- src/hgbs_pkg.sv -----
// Types and constants of the height grid sampler.
`timescale 1ns / 1ps

package hgbs_pkg;

	localparam int COORD_BITS     = 32;
	localparam int FRAC_BITS      = 16;
	localparam int DIM_BITS       = 7;
	localparam int CELL_IDX_BITS  = 12;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// Row * columns + column stays below 2^14 for 7-bit dimensions.
	localparam int ADDR_CALC_BITS = 14;
	// Reciprocal used to reduce an address modulo the store depth.
	localparam int RECIP_SHIFT    = 32;
	localparam int RECIP_BITS     = 33;

	// Result queue depth, a power of two.
	localparam int RSP_FIFO_DEPTH = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ORIGIN_X     = 3'd0,
		CFG_ORIGIN_Z     = 3'd1,
		CFG_INV_CELLSIZE = 3'd2,
		CFG_GRID_COLUMNS = 3'd3,
		CFG_GRID_ROWS    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] height;
		logic                         in_range;
	} rsp_item_t;

endpackage

// ----- src/hgbs_req_if.sv -----
// Request channel: cell writes and height queries.
`timescale 1ns / 1ps

interface hgbs_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [11:0]        cell_index;
	logic signed [31:0] height_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;
	logic               bilinear_mode;

	modport source (
		output valid, opcode, cell_index, height_value, pos_x, pos_z, bilinear_mode,
		input  ready
	);
	modport sink (
		input  valid, opcode, cell_index, height_value, pos_x, pos_z, bilinear_mode,
		output ready
	);
endinterface

// ----- src/hgbs_rsp_if.sv -----
// Response channel: sampled heights.
`timescale 1ns / 1ps

interface hgbs_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] height;
	logic               in_range;

	modport source (
		output valid, height, in_range,
		input  ready
	);
	modport sink (
		input  valid, height, in_range,
		output ready
	);
endinterface

// ----- src/height_grid_bilinear_sampler_core.sv -----
// Top level of the height grid sampler: point and bilinear lookup over a cell grid.
`timescale 1ns / 1ps
`include "height_grid_bilinear_sampler_core_macros.svh"

// Height grid sampler.
// req carries items: opcode OP_WRITE stores height_value at cell_index (ignored
// when beyond the store), opcode OP_QUERY samples the grid at pos_x, pos_z in
// point or bilinear mode. rsp returns one item per query, none per write.
// Configuration goes through cfg_we / cfg_index / cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce this. Throughput: one
// item per cycle while req.ready is high, writes and queries mixed freely. Queries
// walk a ten-stage pipeline and writes leave it at the store stage; the store is
// two copies of one memory, each with two read ports, so the four neighbour
// cells are fetched in the same cycle. A query's result walks the pipeline and
// is then registered in the result queue before rsp sees it; a write lands in
// the store at the store stage, in order with the reads of queries around it.
// Stall: results wait in a 16-entry queue; req.ready drops only when sixteen
// queries are accepted but not yet taken, so the pipeline never stops.
// Reset: clears the pipeline, the queue and the registers to their reset
// values. The store has no clearing pass: a cell reads as garbage until written.

module height_grid_bilinear_sampler_core import hgbs_pkg::*; #(
	parameter int GRID_CELLS  = 4096,
	parameter int HEIGHT_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	hgbs_req_if.sink                  req,
	hgbs_rsp_if.source                rsp
);

	localparam int AW      = $clog2(GRID_CELLS);
	localparam int HB      = HEIGHT_BITS;
	localparam int ACB     = ADDR_CALC_BITS;
	localparam int PmBits  = ACB + RECIP_BITS;
	localparam int CntBits = $clog2(RSP_FIFO_DEPTH + 1);
	localparam int NBits   = $clog2(GRID_CELLS + 1);
	localparam int ModBits = ((NBits > ACB) ? NBits : ACB) + 1;
	localparam logic [RECIP_BITS-1:0] Recip =
		RECIP_BITS'((64'd1 << RECIP_SHIFT) / GRID_CELLS);
	localparam logic [ModBits-1:0] NCells = ModBits'(GRID_CELLS);
	localparam logic [AW-1:0] LastCell = AW'(GRID_CELLS - 1);

	// Configuration registers
	logic signed [COORD_BITS-1:0] origin_x_q;
	logic signed [COORD_BITS-1:0] origin_z_q;
	logic [COORD_BITS-1:0]        ics_q;
	logic [DIM_BITS-1:0]          cols_q;
	logic [DIM_BITS-1:0]          rows_q;

	// Queries accepted and not yet taken at rsp
	logic [CntBits-1:0] cnt_q;

	logic req_acc;
	logic query_acc;
	logic write_acc;
	logic rsp_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			ics_q      <= COORD_BITS'(65536);
			cols_q     <= '0;
			rows_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ORIGIN_X:     origin_x_q <= cfg_wdata;
				CFG_ORIGIN_Z:     origin_z_q <= cfg_wdata;
				CFG_INV_CELLSIZE: ics_q      <= cfg_wdata;
				CFG_GRID_COLUMNS: cols_q     <= cfg_wdata[DIM_BITS-1:0];
				CFG_GRID_ROWS:    rows_q     <= cfg_wdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Admit items while the result queue still has room for every query in flight
	assign req.ready = (cnt_q < CntBits'(RSP_FIFO_DEPTH));
	assign req_acc   = req.valid && req.ready;
	assign query_acc = req_acc && (req.opcode == OP_QUERY);
	assign write_acc = req_acc && (req.opcode == OP_WRITE) &&
		(32'(req.cell_index) < 32'(GRID_CELLS));
	assign rsp_acc   = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (query_acc && !rsp_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (!query_acc && rsp_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Stage valid bits: queries run to the end, writes stop at the store
	logic vq_s1, vq_s2, vq_s3, vq_s4, vq_s5, vq_s6, vq_s7, vq_s8, vq_s9, vq_s10;
	logic vw_s1, vw_s2, vw_s3, vw_s4, vw_s5, vw_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s1 <= 1'b0; vq_s2 <= 1'b0; vq_s3 <= 1'b0; vq_s4  <= 1'b0; vq_s5 <= 1'b0;
			vq_s6 <= 1'b0; vq_s7 <= 1'b0; vq_s8 <= 1'b0; vq_s9  <= 1'b0; vq_s10 <= 1'b0;
			vw_s1 <= 1'b0; vw_s2 <= 1'b0; vw_s3 <= 1'b0; vw_s4  <= 1'b0; vw_s5 <= 1'b0;
			vw_s6 <= 1'b0;
		end else begin
			vq_s1 <= query_acc; vq_s2 <= vq_s1; vq_s3 <= vq_s2; vq_s4  <= vq_s3;
			vq_s5 <= vq_s4;     vq_s6 <= vq_s5; vq_s7 <= vq_s6; vq_s8  <= vq_s7;
			vq_s9 <= vq_s8;     vq_s10 <= vq_s9;
			vw_s1 <= write_acc; vw_s2 <= vw_s1; vw_s3 <= vw_s2; vw_s4  <= vw_s3;
			vw_s5 <= vw_s4;     vw_s6 <= vw_s5;
		end
	end

	// Stage 1: offsets from the grid origin, exact in 33 bits
	logic signed [COORD_BITS:0] dx, dz;
	logic signed [COORD_BITS:0] dx_s1, dz_s1;
	logic                       bil_s1;
	logic [AW-1:0]              wa_s1;
	logic signed [HB-1:0]       hv_s1;

	assign dx = (COORD_BITS+1)'(req.pos_x) - (COORD_BITS+1)'(origin_x_q);
	assign dz = (COORD_BITS+1)'(req.pos_z) - (COORD_BITS+1)'(origin_z_q);

	// Stage 2: scale by the reciprocal cell size, high and low halves apart
	logic [47:0] hx, lx, hz, lz;
	logic [47:0] hx_s2, lx_s2, hz_s2, lz_s2;
	logic        neg_s2, bil_s2;
	logic [AW-1:0]        wa_s2;
	logic signed [HB-1:0] hv_s2;

	assign hx = 48'(dx_s1[31:16]) * 48'(ics_q);
	assign lx = 48'(dx_s1[15:0])  * 48'(ics_q);
	assign hz = 48'(dz_s1[31:16]) * 48'(ics_q);
	assign lz = 48'(dz_s1[15:0])  * 48'(ics_q);

	// Stage 3: cell index, fraction and range test
	logic [47:0]          px, pz;
	logic                 inr;
	logic [DIM_BITS-1:0]  col_s3, row_s3;
	logic [FRAC_BITS-1:0] fx_s3, fz_s3;
	logic                 inr_s3;
	logic [AW-1:0]        wa_s3;
	logic signed [HB-1:0] hv_s3;

	assign px  = hx_s2 + 48'(lx_s2[47:16]);
	assign pz  = hz_s2 + 48'(lz_s2[47:16]);
	assign inr = !neg_s2 && (px[47:16] < 32'(cols_q)) && (pz[47:16] < 32'(rows_q));

	// Stage 4: clamped neighbours and linear addresses of both rows
	logic [DIM_BITS:0]    col_p1, row_p1;
	logic [DIM_BITS-1:0]  col1, row1;
	logic [ACB-1:0]       a0, a1;
	logic [ACB-1:0]       a0_s4, a1_s4;
	logic                 dc_s4;
	logic [FRAC_BITS-1:0] fx_s4, fz_s4;
	logic                 inr_s4;
	logic [AW-1:0]        wa_s4;
	logic signed [HB-1:0] hv_s4;

	assign col_p1 = (DIM_BITS+1)'(col_s3) + 1'b1;
	assign row_p1 = (DIM_BITS+1)'(row_s3) + 1'b1;
	assign col1   = (col_p1 < (DIM_BITS+1)'(cols_q)) ? col_p1[DIM_BITS-1:0] : cols_q - 1'b1;
	assign row1   = (row_p1 < (DIM_BITS+1)'(rows_q)) ? row_p1[DIM_BITS-1:0] : rows_q - 1'b1;
	assign a0     = ACB'(row_s3) * ACB'(cols_q) + ACB'(col_s3);
	assign a1     = ACB'(row1)   * ACB'(cols_q) + ACB'(col_s3);

	// Stage 5: quotient estimate by the store depth, never more than one short
	logic [PmBits-1:0]    pm0, pm1;
	logic [ACB-1:0]       a0_s5, a1_s5, q0_s5, q1_s5;
	logic                 dc_s5;
	logic [FRAC_BITS-1:0] fx_s5, fz_s5;
	logic                 inr_s5;
	logic [AW-1:0]        wa_s5;
	logic signed [HB-1:0] hv_s5;

	assign pm0 = PmBits'(a0_s4) * PmBits'(Recip);
	assign pm1 = PmBits'(a1_s4) * PmBits'(Recip);

	// Stage 6: remainder with one correction step gives the wrapped address
	logic [ModBits-1:0]   r0, r1, m0, m1;
	logic [AW-1:0]        m0_s6, m1_s6;
	logic                 dc_s6;
	logic [FRAC_BITS-1:0] fx_s6, fz_s6;
	logic                 inr_s6;
	logic [AW-1:0]        wa_s6;
	logic signed [HB-1:0] hv_s6;

	assign r0 = ModBits'(a0_s5) - ModBits'(q0_s5) * NCells;
	assign r1 = ModBits'(a1_s5) - ModBits'(q1_s5) * NCells;
	assign m0 = (r0 >= NCells) ? r0 - NCells : r0;
	assign m1 = (r1 >= NCells) ? r1 - NCells : r1;

	// Right neighbour: step one address, wrapping at the end of the store
	logic [AW-1:0] ra0b, ra1b;
	assign ra0b = !dc_s6 ? m0_s6 : ((m0_s6 == LastCell) ? '0 : AW'(m0_s6 + 1'b1));
	assign ra1b = !dc_s6 ? m1_s6 : ((m1_s6 == LastCell) ? '0 : AW'(m1_s6 + 1'b1));

	// Stage 7: cell heights from both store copies; writes land at the same edge
	logic signed [HB-1:0] d00, d01, d10, d11;

	hgbs_store #(
		.DEPTH       (GRID_CELLS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_store_top (
		.clk       (clk),
		.wr_en     (vw_s6),
		.wr_addr   (wa_s6),
		.wr_data   (hv_s6),
		.rd_en     (vq_s6),
		.rd_addr_a (m0_s6),
		.rd_addr_b (ra0b),
		.rd_data_a (d00),
		.rd_data_b (d01)
	);

	hgbs_store #(
		.DEPTH       (GRID_CELLS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_store_bottom (
		.clk       (clk),
		.wr_en     (vw_s6),
		.wr_addr   (wa_s6),
		.wr_data   (hv_s6),
		.rd_en     (vq_s6),
		.rd_addr_a (m1_s6),
		.rd_addr_b (ra1b),
		.rd_data_a (d10),
		.rd_data_b (d11)
	);

	logic [FRAC_BITS-1:0] fx_s7, fz_s7;
	logic                 inr_s7;

	// Stage 8: weight the horizontal differences of both rows
	logic signed [HB:0]    diff_t, diff_b;
	logic signed [HB+17:0] pt, pb;
	logic signed [HB+17:0] pt_s8, pb_s8;
	logic signed [HB-1:0]  d00_s8, d10_s8;
	logic [FRAC_BITS-1:0]  fz_s8;
	logic                  inr_s8;

	assign diff_t = (HB+1)'(d01) - (HB+1)'(d00);
	assign diff_b = (HB+1)'(d11) - (HB+1)'(d10);
	assign pt     = diff_t * $signed({1'b0, fx_s7});
	assign pb     = diff_b * $signed({1'b0, fx_s7});

	// Stage 9: top and bottom row blends; the floor is an arithmetic shift
	logic signed [HB+17:0] sum_t, sum_b;
	logic signed [HB-1:0]  top_s9, bot_s9;
	logic [FRAC_BITS-1:0]  fz_s9;
	logic                  inr_s9;

	assign sum_t = (HB+18)'(d00_s8) + (pt_s8 >>> FRAC_BITS);
	assign sum_b = (HB+18)'(d10_s8) + (pb_s8 >>> FRAC_BITS);

	// Stage 10: weight the vertical difference
	logic signed [HB:0]    diff_z;
	logic signed [HB+17:0] pz_w;
	logic signed [HB+17:0] pz_s10;
	logic signed [HB-1:0]  top_s10;
	logic                  inr_s10;

	assign diff_z = (HB+1)'(bot_s9) - (HB+1)'(top_s9);
	assign pz_w   = diff_z * $signed({1'b0, fz_s9});

	// Final blend; out-of-range queries answer zero
	logic signed [HB+17:0] sum_z;
	logic signed [HB-1:0]  h;
	rsp_item_t             res;

	assign sum_z        = (HB+18)'(top_s10) + (pz_s10 >>> FRAC_BITS);
	assign h            = sum_z[HB-1:0];
	assign res.height   = inr_s10 ? COORD_BITS'(h) : '0;
	assign res.in_range = inr_s10;

	// Pipeline payload: advances every cycle, no reset needed
	always_ff @(posedge clk) begin
		dx_s1  <= dx;
		dz_s1  <= dz;
		bil_s1 <= req.bilinear_mode;
		wa_s1  <= AW'(req.cell_index);
		hv_s1  <= HB'(req.height_value);

		hx_s2  <= hx;
		lx_s2  <= lx;
		hz_s2  <= hz;
		lz_s2  <= lz;
		neg_s2 <= dx_s1[COORD_BITS] || dz_s1[COORD_BITS];
		bil_s2 <= bil_s1;
		wa_s2  <= wa_s1;
		hv_s2  <= hv_s1;

		// Point mode: zero fractions reduce the blend to the base cell
		col_s3 <= px[FRAC_BITS +: DIM_BITS];
		row_s3 <= pz[FRAC_BITS +: DIM_BITS];
		fx_s3  <= bil_s2 ? px[FRAC_BITS-1:0] : '0;
		fz_s3  <= bil_s2 ? pz[FRAC_BITS-1:0] : '0;
		inr_s3 <= inr;
		wa_s3  <= wa_s2;
		hv_s3  <= hv_s2;

		a0_s4  <= a0;
		a1_s4  <= a1;
		dc_s4  <= (col1 != col_s3);
		fx_s4  <= fx_s3;
		fz_s4  <= fz_s3;
		inr_s4 <= inr_s3;
		wa_s4  <= wa_s3;
		hv_s4  <= hv_s3;

		a0_s5  <= a0_s4;
		a1_s5  <= a1_s4;
		q0_s5  <= pm0[RECIP_SHIFT +: ACB];
		q1_s5  <= pm1[RECIP_SHIFT +: ACB];
		dc_s5  <= dc_s4;
		fx_s5  <= fx_s4;
		fz_s5  <= fz_s4;
		inr_s5 <= inr_s4;
		wa_s5  <= wa_s4;
		hv_s5  <= hv_s4;

		m0_s6  <= AW'(m0);
		m1_s6  <= AW'(m1);
		dc_s6  <= dc_s5;
		fx_s6  <= fx_s5;
		fz_s6  <= fz_s5;
		inr_s6 <= inr_s5;
		wa_s6  <= wa_s5;
		hv_s6  <= hv_s5;

		fx_s7  <= fx_s6;
		fz_s7  <= fz_s6;
		inr_s7 <= inr_s6;

		pt_s8  <= pt;
		pb_s8  <= pb;
		d00_s8 <= d00;
		d10_s8 <= d10;
		fz_s8  <= fz_s7;
		inr_s8 <= inr_s7;

		top_s9 <= sum_t[HB-1:0];
		bot_s9 <= sum_b[HB-1:0];
		fz_s9  <= fz_s8;
		inr_s9 <= inr_s8;

		pz_s10  <= pz_w;
		top_s10 <= top_s9;
		inr_s10 <= inr_s9;
	end

	hgbs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vq_s10),
		.push_item (res),
		.rsp       (rsp)
	);

	`HGBS_ASSERT(a_credit_bound, cnt_q <= CntBits'(RSP_FIFO_DEPTH), "query credit count above queue depth")
	`HGBS_ASSERT(a_result_has_credit, vq_s10 |-> (cnt_q != '0), "result pushed without an outstanding query")
	`HGBS_ASSERT_NEVER(a_store_port_clash, vq_s6 && vw_s6, "write and query share the store stage")
	`HGBS_ASSERT(a_out_of_range_zero, (rsp.valid && !rsp.in_range) |-> (rsp.height == '0), "out-of-range result carries a height")

endmodule

// ----- src/hgbs_store.sv -----
// Height store copy: one write port, two registered read ports.
`timescale 1ns / 1ps

module hgbs_store #(
	parameter int DEPTH       = 4096,
	parameter int HEIGHT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  logic signed [HEIGHT_BITS-1:0]       wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr_b,
	output logic signed [HEIGHT_BITS-1:0]       rd_data_a,
	output logic signed [HEIGHT_BITS-1:0]       rd_data_b
);

	logic signed [HEIGHT_BITS-1:0] mem [DEPTH];
	logic signed [HEIGHT_BITS-1:0] rd_a_q;
	logic signed [HEIGHT_BITS-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ----- src/hgbs_fifo.sv -----
// Result queue between the sampling pipeline and the response channel.
`timescale 1ns / 1ps
`include "height_grid_bilinear_sampler_core_macros.svh"

module hgbs_fifo import hgbs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rsp_item_t     push_item,
	hgbs_rsp_if.source    rsp
);

	localparam int PtrBits = $clog2(RSP_FIFO_DEPTH);
	localparam int CntBits = $clog2(RSP_FIFO_DEPTH + 1);

	rsp_item_t          mem_q [RSP_FIFO_DEPTH];
	logic [PtrBits-1:0] wr_ptr_q;
	logic [PtrBits-1:0] rd_ptr_q;
	logic [CntBits-1:0] count_q;
	logic               pop;
	rsp_item_t          head;

	assign pop       = rsp.valid && rsp.ready;
	assign head      = mem_q[rd_ptr_q];
	assign rsp.valid = (count_q != '0);
	assign rsp.height   = head.height;
	assign rsp.in_range = head.in_range;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`HGBS_ASSERT_NEVER(a_fifo_overflow, push && !pop && count_q == CntBits'(RSP_FIFO_DEPTH), "result queue overflow")
	`HGBS_ASSERT(a_fifo_ptr_gap, count_q[PtrBits-1:0] == PtrBits'(wr_ptr_q - rd_ptr_q), "result queue pointers disagree with count")

endmodule
